// ----- rtl/core/ritp_pkg.sv -----
package ritp_pkg;

   typedef struct packed {
      logic [7:0] sym_char;
      logic       end_of_expr;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       symbol_valid;
      logic       run_last;
      logic       expr_done;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_OPEN  = 3'd0,
      OP_ALT   = 3'd1,
      OP_CAT   = 3'd2,
      OP_STAR  = 3'd3,
      OP_PLUS  = 3'd4,
      OP_QUEST = 3'd5
   } op_code_type;

   typedef enum logic [1:0] {
      KIND_LIT,
      KIND_OPEN,
      KIND_CLOSE,
      KIND_OPER
   } kind_type;

   // classified character as it travels from front to back
   typedef struct packed {
      logic [7:0]  sym_char;
      kind_type    kind;
      op_code_type code;
      logic        end_of_expr;
   } item_type;

   localparam logic [7:0] CHAR_ALT   = 8'h7C;
   localparam logic [7:0] CHAR_CAT   = 8'h2E;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_QUEST = 8'h3F;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;

   localparam logic [1:0] PREC_OPEN  = 2'd0;
   localparam logic [1:0] PREC_ALT   = 2'd1;
   localparam logic [1:0] PREC_CAT   = 2'd2;
   localparam logic [1:0] PREC_UNARY = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNMATCHED = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   function automatic logic [7:0] code_char(input op_code_type code);
      logic [7:0] ch;
      case (code)
         OP_OPEN:  ch = CHAR_OPEN;
         OP_ALT:   ch = CHAR_ALT;
         OP_CAT:   ch = CHAR_CAT;
         OP_STAR:  ch = CHAR_STAR;
         OP_PLUS:  ch = CHAR_PLUS;
         OP_QUEST: ch = CHAR_QUEST;
         default:  ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [1:0] code_prec(input op_code_type code);
      logic [1:0] prec;
      case (code)
         OP_OPEN:  prec = PREC_OPEN;
         OP_ALT:   prec = PREC_ALT;
         OP_CAT:   prec = PREC_CAT;
         OP_STAR:  prec = PREC_UNARY;
         OP_PLUS:  prec = PREC_UNARY;
         OP_QUEST: prec = PREC_UNARY;
         default:  prec = PREC_OPEN;
      endcase
      return prec;
   endfunction

endpackage

// ----- rtl/core/ritp_front.sv -----
module ritp_front (
   input  logic               req_valid,
   output logic               req_stall,
   input  ritp_pkg::req_type  req_data,
   output logic               push,
   output ritp_pkg::item_type push_item,
   input  logic               q_full
);

   always_comb begin
      push_item.sym_char    = req_data.sym_char;
      push_item.end_of_expr = req_data.end_of_expr;
      push_item.kind        = ritp_pkg::KIND_OPER;
      push_item.code        = ritp_pkg::OP_OPEN;
      case (req_data.sym_char)
         ritp_pkg::CHAR_ALT:   push_item.code = ritp_pkg::OP_ALT;
         ritp_pkg::CHAR_CAT:   push_item.code = ritp_pkg::OP_CAT;
         ritp_pkg::CHAR_STAR:  push_item.code = ritp_pkg::OP_STAR;
         ritp_pkg::CHAR_PLUS:  push_item.code = ritp_pkg::OP_PLUS;
         ritp_pkg::CHAR_QUEST: push_item.code = ritp_pkg::OP_QUEST;
         ritp_pkg::CHAR_OPEN:  push_item.kind = ritp_pkg::KIND_OPEN;
         ritp_pkg::CHAR_CLOSE: push_item.kind = ritp_pkg::KIND_CLOSE;
         default:              push_item.kind = ritp_pkg::KIND_LIT;
      endcase
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

endmodule

// ----- rtl/core/ritp_queue.sv -----
module ritp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ritp_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output ritp_pkg::item_type pop_item
);

   localparam logic [ritp_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      ritp_pkg::QUEUE_CNT_W'(ritp_pkg::QUEUE_DEPTH);

   ritp_pkg::item_type                  entry_ff [ritp_pkg::QUEUE_DEPTH];
   logic [ritp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ritp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ritp_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                                do_push, do_pop;

   assign full      = count_ff == CNT_FULL;
   assign not_empty = count_ff != '0;
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + ritp_pkg::QUEUE_CNT_W'(do_push)
                  - ritp_pkg::QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/ritp_back.sv -----
module ritp_back #(
   parameter int STACK_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  ritp_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ritp_pkg::rsp_type  rsp_data
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int IW = $clog2(STACK_DEPTH);
   localparam logic [CW-1:0] DEPTH_FULL = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] DEPTH_NEAR = CW'(STACK_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PEEK,
      S_CAT,
      S_MAIN,
      S_FLUSH,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   ritp_pkg::item_type     item_ff, item_in;
   logic [1:0]             status_ff, status_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          open_cnt_ff, open_cnt_in;
   logic                   prev_end_ff, prev_end_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [7:0]             pend_char_ff, pend_char_in;
   logic                   out_valid_ff, out_valid_in;
   ritp_pkg::rsp_type      out_data_ff, out_data_in;
   ritp_pkg::op_code_type  stack_ff [STACK_DEPTH];

   logic [IW-1:0]          rd_idx;
   ritp_pkg::op_code_type  rd_code;
   logic [1:0]             rd_prec;
   logic                   out_free, full, near_full, hold, fire, start;
   logic                   emit, pop, push, open_inc, open_dec, finish, take;
   logic [7:0]             emit_char;
   ritp_pkg::op_code_type  push_code;
   logic                   qual_cur, qual_new, need_cat, top_low;
   logic [1:0]             new_prec, cur_prec;

   // one stack read a cycle: the top, or the entry below it while peeking
   always_comb begin
      if (state_ff == S_PEEK) begin
         rd_idx = IW'(count_ff - CW'(2));
      end else begin
         rd_idx = IW'(count_ff - CW'(1));
      end
   end

   assign rd_code   = stack_ff[rd_idx];
   assign rd_prec   = ritp_pkg::code_prec(rd_code);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign full      = count_ff == DEPTH_FULL;
   assign near_full = count_ff == DEPTH_NEAR;
   assign top_low   = rd_prec < ritp_pkg::PREC_CAT;
   assign new_prec  = ritp_pkg::code_prec(q_item.code);
   assign cur_prec  = ritp_pkg::code_prec(item_ff.code);
   assign qual_new  = (new_prec != ritp_pkg::PREC_UNARY) && (rd_prec >= new_prec);
   assign qual_cur  = (cur_prec != ritp_pkg::PREC_UNARY) && (rd_prec >= cur_prec);
   assign need_cat  = prev_end_ff &&
                      (q_item.kind == ritp_pkg::KIND_LIT || q_item.kind == ritp_pkg::KIND_OPEN);

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      status_in   = status_ff;
      prev_end_in = prev_end_ff;
      emit        = 1'b0;
      emit_char   = 8'h00;
      pop         = 1'b0;
      push        = 1'b0;
      push_code   = ritp_pkg::OP_OPEN;
      open_inc    = 1'b0;
      open_dec    = 1'b0;
      finish      = 1'b0;
      start       = 1'b0;
      take        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            start = 1'b1;
         end
         S_PEEK: begin
            // full stack, '.' pops the top: '(' overflows unless '.' pops twice
            status_in = top_low ? ritp_pkg::STATUS_OVERFLOW : ritp_pkg::STATUS_OK;
            state_in  = S_CAT;
         end
         S_CAT: begin
            if (count_ff != '0 && rd_prec >= ritp_pkg::PREC_CAT) begin
               emit      = 1'b1;
               emit_char = ritp_pkg::code_char(rd_code);
               pop       = 1'b1;
            end else begin
               push      = !full;
               push_code = ritp_pkg::OP_CAT;
               state_in  = S_MAIN;
            end
         end
         S_MAIN: begin
            case (item_ff.kind)
               ritp_pkg::KIND_LIT: begin
                  emit      = 1'b1;
                  emit_char = item_ff.sym_char;
                  state_in  = item_ff.end_of_expr ? S_FLUSH : S_DONE;
               end
               ritp_pkg::KIND_OPEN: begin
                  push      = !full;
                  open_inc  = !full;
                  push_code = ritp_pkg::OP_OPEN;
                  state_in  = item_ff.end_of_expr ? S_FLUSH : S_DONE;
               end
               ritp_pkg::KIND_CLOSE: begin
                  if (count_ff != '0 && rd_code != ritp_pkg::OP_OPEN) begin
                     emit      = 1'b1;
                     emit_char = ritp_pkg::code_char(rd_code);
                     pop       = 1'b1;
                  end else begin
                     // drop the matching '(' if there is one
                     pop      = count_ff != '0;
                     open_dec = count_ff != '0;
                     state_in = item_ff.end_of_expr ? S_FLUSH : S_DONE;
                  end
               end
               ritp_pkg::KIND_OPER: begin
                  if (count_ff != '0 && qual_cur) begin
                     emit      = 1'b1;
                     emit_char = ritp_pkg::code_char(rd_code);
                     pop       = 1'b1;
                  end else begin
                     push      = !full;
                     push_code = item_ff.code;
                     state_in  = item_ff.end_of_expr ? S_FLUSH : S_DONE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_FLUSH: begin
            if (count_ff != '0) begin
               emit      = 1'b1;
               emit_char = ritp_pkg::code_char(rd_code);
               pop       = 1'b1;
               open_dec  = rd_code == ritp_pkg::OP_OPEN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            finish = 1'b1;
            start  = out_free;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (start) begin
         state_in = S_IDLE;
         if (q_valid) begin
            take        = 1'b1;
            item_in     = q_item;
            status_in   = ritp_pkg::STATUS_OK;
            state_in    = need_cat ? S_CAT : S_MAIN;
            prev_end_in = !q_item.end_of_expr &&
                          (q_item.kind == ritp_pkg::KIND_LIT ||
                           q_item.kind == ritp_pkg::KIND_CLOSE ||
                           (q_item.kind == ritp_pkg::KIND_OPER &&
                            new_prec == ritp_pkg::PREC_UNARY));
            // settle the item's status before its first beat goes out
            case (q_item.kind)
               ritp_pkg::KIND_LIT: begin
                  if (need_cat && full && top_low) begin
                     status_in = ritp_pkg::STATUS_OVERFLOW;
                  end
               end
               ritp_pkg::KIND_OPEN: begin
                  if (!need_cat) begin
                     if (full) begin
                        status_in = ritp_pkg::STATUS_OVERFLOW;
                     end
                  end else if ((near_full || full) && top_low) begin
                     status_in = ritp_pkg::STATUS_OVERFLOW;
                  end else if (full) begin
                     state_in = S_PEEK;
                  end
               end
               ritp_pkg::KIND_CLOSE: begin
                  if (open_cnt_ff == '0) begin
                     status_in = ritp_pkg::STATUS_UNMATCHED;
                  end
               end
               ritp_pkg::KIND_OPER: begin
                  if (full && !qual_new) begin
                     status_in = ritp_pkg::STATUS_OVERFLOW;
                  end
               end
               default: begin
                  status_in = ritp_pkg::STATUS_OK;
               end
            endcase
         end
      end
   end

   assign hold  = (emit && pend_valid_ff && !out_free) || (finish && !out_free);
   assign fire  = !hold;
   assign q_pop = take;

   // one symbol waits in the pending slot until we know whether it closes the item
   always_comb begin
      count_in      = count_ff;
      open_cnt_in   = open_cnt_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_data_in   = out_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      if (fire) begin
         count_in    = count_ff + CW'(push) - CW'(pop);
         open_cnt_in = open_cnt_ff + CW'(open_inc) - CW'(open_dec);
         if (emit) begin
            if (pend_valid_ff) begin
               out_valid_in             = 1'b1;
               out_data_in.out_char     = pend_char_ff;
               out_data_in.symbol_valid = 1'b1;
               out_data_in.run_last     = 1'b0;
               out_data_in.expr_done    = 1'b0;
               out_data_in.status       = status_ff;
            end
            pend_valid_in = 1'b1;
            pend_char_in  = emit_char;
         end else if (finish) begin
            out_valid_in             = 1'b1;
            out_data_in.out_char     = pend_valid_ff ? pend_char_ff : 8'h00;
            out_data_in.symbol_valid = pend_valid_ff;
            out_data_in.run_last     = 1'b1;
            out_data_in.expr_done    = item_ff.end_of_expr;
            out_data_in.status       = status_ff;
            pend_valid_in            = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         open_cnt_ff   <= '0;
         prev_end_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= fire ? state_in : state_ff;
         count_ff      <= count_in;
         open_cnt_ff   <= open_cnt_in;
         prev_end_ff   <= fire ? prev_end_in : prev_end_ff;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      if (fire) begin
         item_ff   <= item_in;
         status_ff <= status_in;
         if (push) begin
            stack_ff[IW'(count_ff)] <= push_code;
         end
      end
      pend_char_ff <= pend_char_in;
      out_data_ff  <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_FULL)
      else $error("operator stack count beyond depth");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_cnt_ff <= count_ff)
      else $error("open paren count exceeds stack count");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("pending symbol left behind at idle");

   a_peek_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PEEK |-> count_ff == DEPTH_FULL)
      else $error("peek entered without a full stack");

   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rsp_valid && rsp_data.run_last))
      else $error("item close did not produce a last beat");

endmodule

// ----- rtl/core/regex_infix_to_postfix_unit.sv -----
// Channel  Ports                        Payload
// -------  ---------------------------  --------------------------------------------
// input    req_valid, req_stall         req_data: sym_char, end_of_expr
// output   rsp_valid, rsp_stall         rsp_data: out_char, symbol_valid, run_last,
//                                                 expr_done, status
//
// Steps: a literal with nothing to concatenate goes through S_MAIN and S_DONE; an inserted
// '.' adds S_CAT. Every operator popped off the stack (by an operator, ')' or the end
// flush) adds a step, as the back engine does one stack access per cycle while not held;
// end of expression adds S_FLUSH, and '(' on a full stack after an operand adds an S_PEEK
// look below the top. Reset clears the stack count, the queue and both output slots; stack
// contents are not cleared. A stalled output holds the engine only when it has a new beat to
// pass on; the front keeps taking characters into a two-entry queue meanwhile.
module regex_infix_to_postfix_unit #(
   parameter int STACK_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ritp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ritp_pkg::rsp_type rsp_data
);

   logic               q_push, q_full, q_pop, q_valid;
   ritp_pkg::item_type q_push_item, q_pop_item;

   ritp_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (q_push),
      .push_item (q_push_item),
      .q_full    (q_full)
   );

   ritp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_item  (q_pop_item)
   );

   ritp_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_pop_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
